// ===== rtl/pispd_pkg.sv =====
`default_nettype none

package pispd_pkg;

  // Fraction bits of the fixed-point speeds, gains, limit and effort; products carry twice as many.
  localparam int FRAC_BITS = 16;

  localparam int DATA_W   = 32;
  localparam int ERR_W    = 33;
  localparam int SUM_W    = 34;
  localparam int LIM_W    = 31;
  localparam int PER_W    = 17;
  localparam int PROD_W   = 64;
  localparam int MAG_W    = 17;
  localparam int EFF_W    = 18;
  localparam int IN_W     = 64;
  localparam int OUT_W    = 40;
  localparam int ADDR_W   = 4;

  // Unity squared, the saturation threshold of the unscaled effort.
  localparam logic [PROD_W:0] ONE_SQ = (PROD_W + 1)'(1) << (2 * FRAC_BITS);
  // Unity in the effort format.
  localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << FRAC_BITS;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_KP     = 2'd0;
  localparam logic [1:0] REG_KI     = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;
  localparam logic [1:0] REG_PERIOD = 2'd3;

  localparam logic [31:0] KP_RESET     = 32'd118942;
  localparam logic [31:0] KI_RESET     = 32'd2170;
  localparam logic [30:0] LIMIT_RESET  = 31'd1979030;
  localparam logic [16:0] PERIOD_RESET = 17'd50;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_SUM,
    S_CLAMP,
    S_IABS,
    S_IMUL,
    S_COMB,
    S_SAT,
    S_PULSE,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/pi_speed_loop_pwm_drive.sv =====
// A new request is accepted only in S_IDLE, once the previous one has left S_OUT.
// The sequencer works on one request at a time with a single shared 32x32 multiplier,
// which is used three times per request under a ten-state sequencer.
// Reset (rst, synchronous, active high) restores the gain, limit and period registers,
// clears the integral sum and empties the output register.
`default_nettype none

module pi_speed_loop_pwm_drive (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Slave side, tdata from bit 0: setpoint[31:0], measured_speed[63:32].
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [pispd_pkg::IN_W-1:0]    s_tdata,
  // Master side, tdata from bit 0: pulse_width[16:0], direction[17],
  // effort[35:18], saturated[36], zero fill[39:37].
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [pispd_pkg::OUT_W-1:0]        m_tdata,
  // Configuration port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pispd_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  import pispd_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers. The port is always ready, so a write lands at the
  // edge of its access cycle. The register index is the word address.
  // ---------------------------------------------------------------------------
  logic [31:0]       kp;
  logic [31:0]       ki;
  logic [LIM_W-1:0]  limit;
  logic [PER_W-1:0]  period;
  logic              cfg_write;
  logic [1:0]        cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      kp     <= KP_RESET;
      ki     <= KI_RESET;
      limit  <= LIMIT_RESET;
      period <= PERIOD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KP:     kp     <= pwdata;
        REG_KI:     ki     <= pwdata;
        REG_LIMIT:  limit  <= pwdata[LIM_W-1:0];
        REG_PERIOD: period <= pwdata[PER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_KP:     prdata = kp;
      REG_KI:     prdata = ki;
      REG_LIMIT:  prdata = {1'b0, limit};
      REG_PERIOD: prdata = {15'd0, period};
      default:    prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer. Each request walks through the states below in order:
  //   S_ERR    error = setpoint - measured speed (33 bits, exact)
  //   S_SUM    raw integral = stored sum + error, and the error magnitude
  //   S_CLAMP  clamp the integral to +/- limit; multiplier forms kp * |error|
  //   S_IABS   keep the proportional product, take the integral magnitude
  //   S_IMUL   multiplier forms ki * |integral|
  //   S_COMB   signed sum of the two products as sign and magnitude (65 bits)
  //   S_SAT    saturate at one and truncate to the effort format
  //   S_PULSE  multiplier forms |effort| * pwm period
  //   S_OUT    load the output register, waiting while it is still occupied
  // ---------------------------------------------------------------------------
  state_t state;
  state_t state_next;

  logic [31:0]        a_in;
  logic [31:0]        b_in;
  logic [ERR_W-1:0]   err;
  logic [SUM_W-1:0]   sum_raw;
  logic [31:0]        emag;
  logic [31:0]        integ;
  logic [LIM_W-1:0]   imag;
  logic [PROD_W-1:0]  pm;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W:0]    m;
  logic               m_neg;
  logic [MAG_W-1:0]   mag;
  logic               mag_neg;
  logic               sat;

  // Control decoded from the state.
  logic               out_load;
  logic [31:0]        mul_x;
  logic [31:0]        mul_y;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (s_tvalid) state_next = S_ERR;
      S_ERR:   state_next = S_SUM;
      S_SUM:   state_next = S_CLAMP;
      S_CLAMP: state_next = S_IABS;
      S_IABS:  state_next = S_IMUL;
      S_IMUL:  state_next = S_COMB;
      S_COMB:  state_next = S_SAT;
      S_SAT:   state_next = S_PULSE;
      S_PULSE: state_next = S_OUT;
      S_OUT:   if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // The shared multiplier takes its operands from the state: the proportional
  // gain in S_CLAMP, the integral gain in S_IMUL and the PWM period otherwise.
  // No request is taken while reset is held.
  always_comb begin
    s_tready = 1'b0;
    out_load = 1'b0;
    mul_x    = {15'd0, mag};
    mul_y    = {15'd0, period};
    case (state)
      S_IDLE: s_tready = !rst;
      S_CLAMP: begin
        mul_x = kp;
        mul_y = emag;
      end
      S_IMUL: begin
        mul_x = ki;
        mul_y = {1'b0, imag};
      end
      S_OUT: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath.
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_s;
  logic signed [SUM_W-1:0] lim_pos;
  logic signed [SUM_W-1:0] lim_neg;
  logic [31:0]             integ_clamped;
  logic [31:0]             err_neg;
  logic [LIM_W-1:0]        integ_neg;
  logic [PROD_W:0]         m_add;
  logic                    pm_ge;
  logic                    sat_now;
  logic [MAG_W-1:0]        mag_now;

  // The error magnitude always fits 32 bits and the integral magnitude 31 bits,
  // so only the low bits of each negation are formed.
  assign sum_s     = $signed(sum_raw);
  assign lim_pos   = $signed({3'd0, limit});
  assign lim_neg   = -lim_pos;
  assign err_neg   = -err[31:0];
  assign integ_neg = -integ[LIM_W-1:0];

  // The clamped sum always fits 32 bits since the limit is below 2^31.
  always_comb begin
    if (sum_s > lim_pos) begin
      integ_clamped = lim_pos[31:0];
    end else if (sum_s < lim_neg) begin
      integ_clamped = lim_neg[31:0];
    end else begin
      integ_clamped = sum_raw[31:0];
    end
  end

  // Products of like sign add; otherwise the larger one keeps its sign.
  assign pm_ge = pm >= prod;
  always_comb begin
    if (err[ERR_W-1] == integ[31]) begin
      m_add = {1'b0, pm} + {1'b0, prod};
    end else if (pm_ge) begin
      m_add = {1'b0, pm - prod};
    end else begin
      m_add = {1'b0, prod - pm};
    end
  end

  assign sat_now = m > ONE_SQ;
  assign mag_now = sat_now ? ONE_MAG : m[FRAC_BITS +: MAG_W];

  always_ff @(posedge clk) begin
    prod <= {32'd0, mul_x} * {32'd0, mul_y};
    if (s_tvalid && s_tready) begin
      a_in <= s_tdata[31:0];
      b_in <= s_tdata[63:32];
    end
    case (state)
      S_ERR: err <= {a_in[31], a_in} - {b_in[31], b_in};
      S_SUM: begin
        sum_raw <= {{2{integ[31]}}, integ} + {err[ERR_W-1], err};
        emag    <= err[ERR_W-1] ? err_neg : err[31:0];
      end
      S_IABS: begin
        pm   <= prod;
        imag <= integ[31] ? integ_neg : integ[LIM_W-1:0];
      end
      S_COMB: begin
        m     <= m_add;
        m_neg <= (err[ERR_W-1] == integ[31]) ? err[ERR_W-1] :
                 (pm_ge ? err[ERR_W-1] : integ[31]);
      end
      S_SAT: begin
        mag     <= mag_now;
        sat     <= sat_now;
        mag_neg <= m_neg && (mag_now != '0);
      end
      default: ;
    endcase
  end

  // The integral sum is state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
    end else if (state == S_CLAMP) begin
      integ <= integ_clamped;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. It holds a finished result while the sequencer already
  // takes the next request; only the final load step waits for it to drain.
  // ---------------------------------------------------------------------------
  logic [EFF_W-1:0] effort_now;
  logic             dir_now;

  assign effort_now = mag_neg ? -{1'b0, mag} : {1'b0, mag};
  assign dir_now    = !mag_neg && (mag != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'd0, sat, effort_now, dir_now, prod[FRAC_BITS +: MAG_W]};
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_ERR))
    else $error("accepted request did not start the sequencer");

  a_integ_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_IABS) |->
      ($signed(integ) <= $signed({1'b0, limit}) &&
       $signed(integ) >= -$signed({1'b0, limit})))
    else $error("integral sum outside its limit");

  a_effort_bounded: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[35:18]) <= 18'sd65536 &&
                  $signed(m_tdata[35:18]) >= -18'sd65536))
    else $error("effort beyond plus or minus one");

  a_dir_positive: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[17]) |-> ($signed(m_tdata[35:18]) > 18'sd0))
    else $error("forward direction without positive effort");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten while occupied");

endmodule

`default_nettype wire
